/* design/wtm_pkg.sv */
// shared types and constants for the wavetable mix and error meter
`default_nettype none

package wtm_pkg;

  // voices and waveform table geometry
  localparam int NUM_VOICES  = 4;
  localparam int NUM_WAVES   = 256;
  localparam int WAVE_LEN    = 'h100;
  localparam int PHASE_SHIFT = 8;
  localparam int GAIN_SHIFT  = 10;

  localparam int TABLE_DEPTH = NUM_WAVES * WAVE_LEN;
  localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
  localparam int VOICE_IW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  // datapath widths
  localparam int SAMPLE_W = 16;
  localparam int PHASE_W  = 16;
  localparam int GAIN_W   = 8;
  localparam int WSEL_W   = 8;
  localparam int OPND_W   = SAMPLE_W + 1;
  localparam int PROD_W   = 2 * OPND_W;
  localparam int TOTAL_W  = 64;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_WAVE  = 2'd1,
    CMD_CHAN  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_MUL,
    ST_ACC,
    ST_DIFF,
    ST_TOT,
    ST_DONE
  } state_t;

  // sequencer strobes to the datapath
  typedef struct packed {
    logic clr_phase;
    logic clr_total;
    logic wave_wr;
    logic chan_set;
    logic tick_start;
    logic phase_step;
    logic mul_voice;
    logic acc_voice;
    logic mul_sq;
    logic acc_total;
    logic load_out;
  } ctl_t;

endpackage

`default_nettype wire

/* design/wtm_ram.sv */
// generic simple dual-port ram with registered read
`default_nettype none

module wtm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/wtm_voices.sv */
// voice register bank: phase, rate, gain and waveform per voice
`default_nettype none

module wtm_voices
  import wtm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctl_t                ctl,
  input  wire logic [VOICE_IW-1:0] vsel,
  input  wire logic [1:0]          channel,
  input  wire logic [WSEL_W-1:0]   waveform,
  input  wire logic [PHASE_W-1:0]  step_rate,
  input  wire logic [GAIN_W-1:0]   volume,
  output logic [TABLE_AW-1:0]      raddr,
  output logic                     wave_ok,
  output logic [GAIN_W-1:0]        gain
);

  logic [PHASE_W-1:0] phase [NUM_VOICES];
  logic [PHASE_W-1:0] rate  [NUM_VOICES];
  logic [GAIN_W-1:0]  gains [NUM_VOICES];
  logic [WSEL_W-1:0]  waves [NUM_VOICES];

  logic [4:0]          chan_ext;
  logic                chan_ok;
  logic [VOICE_IW-1:0] chan_idx;
  logic [PHASE_W-1:0]  phase_next;
  logic [WSEL_W-1:0]   sel_wave;

  // channel decode, out of range channels are dropped
  assign chan_ext = {3'b000, channel};
  assign chan_ok  = chan_ext < 5'(NUM_VOICES);
  assign chan_idx = chan_ext[VOICE_IW-1:0];

  // phase advance and table address for the selected voice
  assign phase_next = phase[vsel] + rate[vsel];
  assign sel_wave   = waves[vsel];
  assign raddr      = TABLE_AW'({sel_wave, phase_next[PHASE_W-1:PHASE_SHIFT]});
  assign wave_ok    = {1'b0, sel_wave} < 9'(NUM_WAVES);
  assign gain       = gains[vsel];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_VOICES; i++) begin
        phase[i] <= '0;
        rate[i]  <= '0;
        gains[i] <= '0;
        waves[i] <= '0;
      end
    end else begin
      if (ctl.clr_phase) begin
        for (int i = 0; i < NUM_VOICES; i++) begin
          phase[i] <= '0;
        end
      end
      if (ctl.phase_step) begin
        phase[vsel] <= phase_next;
      end
      if (ctl.chan_set && chan_ok) begin
        rate[chan_idx]  <= step_rate;
        gains[chan_idx] <= volume;
        waves[chan_idx] <= waveform;
      end
    end
  end

endmodule

`default_nettype wire

/* design/wtm_arith.sv */
// shared multiplier with mix and squared error accumulators
`default_nettype none

module wtm_arith
  import wtm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire ctl_t                       ctl,
  input  wire logic signed [SAMPLE_W-1:0] target_sample,
  input  wire logic        [SAMPLE_W-1:0] rdata,
  input  wire logic                       wave_ok,
  input  wire logic        [GAIN_W-1:0]   gain,
  output logic signed [SAMPLE_W-1:0]      mixed_sample,
  output logic        [TOTAL_W-1:0]       error_total,
  output logic                            exact_so_far
);

  logic signed [SAMPLE_W-1:0] target_q;
  logic        [SAMPLE_W-1:0] mix_acc;
  logic        [TOTAL_W-1:0]  total;
  logic signed [PROD_W-1:0]   prod;

  logic signed [OPND_W-1:0]   mul_a;
  logic signed [OPND_W-1:0]   mul_b;
  logic signed [OPND_W-1:0]   diff;
  logic signed [PROD_W-1:0]   scaled;

  // target minus wrapped mix, exact in 17 bits
  assign diff = $signed({target_q[SAMPLE_W-1], target_q})
              - $signed({mix_acc[SAMPLE_W-1], mix_acc});

  // operand select for the one multiplier
  always_comb begin
    if (ctl.mul_sq) begin
      mul_a = diff;
      mul_b = diff;
    end else begin
      mul_a = $signed({{(OPND_W-GAIN_W){1'b0}}, gain});
      mul_b = wave_ok ? $signed({rdata[SAMPLE_W-1], rdata}) : '0;
    end
  end

  // gain shift rounds toward minus infinity
  assign scaled = prod >>> GAIN_SHIFT;

  // product register and mix accumulator
  always_ff @(posedge clk) begin
    if (ctl.tick_start) begin
      target_q <= target_sample;
      mix_acc  <= '0;
    end
    if (ctl.mul_voice || ctl.mul_sq) begin
      prod <= mul_a * mul_b;
    end
    if (ctl.acc_voice) begin
      mix_acc <= mix_acc + scaled[SAMPLE_W-1:0];
    end
  end

  // running squared error total
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (ctl.clr_total) begin
      total <= '0;
    end else if (ctl.acc_total) begin
      total <= total + TOTAL_W'(unsigned'(prod));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      mixed_sample <= $signed(mix_acc);
      error_total  <= total;
      exact_so_far <= (total == '0);
    end
  end

endmodule

`default_nettype wire

/* design/wtm_ctrl.sv */
// command decode and per-tick sequencer
`default_nettype none

module wtm_ctrl
  import wtm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic [1:0]          cmd,
  input  wire logic                out_stall,
  output logic                     in_stall,
  output logic                     out_valid,
  output ctl_t                     ctl,
  output logic [VOICE_IW-1:0]      vsel
);

  state_t              state;
  state_t              state_next;
  logic [VOICE_IW-1:0] vsel_next;
  logic                last_voice;

  assign in_stall   = (state != ST_IDLE);
  assign last_voice = (vsel == VOICE_IW'(NUM_VOICES - 1));

  // state and voice counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      vsel  <= '0;
    end else begin
      state <= state_next;
      vsel  <= vsel_next;
    end
  end

  // result valid, held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    vsel_next  = vsel;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (cmd_t'(cmd))
            CMD_START: begin
              ctl.clr_phase = 1'b1;
              ctl.clr_total = 1'b1;
            end
            CMD_WAVE: ctl.wave_wr  = 1'b1;
            CMD_CHAN: ctl.chan_set = 1'b1;
            CMD_TICK: begin
              ctl.tick_start = 1'b1;
              vsel_next      = '0;
              state_next     = ST_ADDR;
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADDR: begin
        ctl.phase_step = 1'b1;
        state_next     = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul_voice = 1'b1;
        state_next    = ST_ACC;
      end
      ST_ACC: begin
        ctl.acc_voice = 1'b1;
        if (last_voice) begin
          state_next = ST_DIFF;
        end else begin
          vsel_next  = vsel + 1'b1;
          state_next = ST_ADDR;
        end
      end
      ST_DIFF: begin
        ctl.mul_sq = 1'b1;
        state_next = ST_TOT;
      end
      ST_TOT: begin
        ctl.acc_total = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

/* design/wavetable_mix_error_meter.sv */
// top level of the four-voice wavetable mixer and squared error meter
//
// One input channel (in_valid / in_stall) carries commands: start, wave
// sample write, channel set and sample tick. One output channel
// (out_valid / out_stall) carries a result item for each sample tick only.
// Start, wave write and channel set may follow one another every cycle
// while the sequencer is idle. A sample tick runs through the voices one at
// a time on a single shared multiplier and the one table read port: for
// each voice a phase step and table read, a multiply and an accumulate,
// then the error is squared and added. The result is registered as the
// sequencer leaves its done state, and no new item is taken until it is
// back in idle; in_stall is high for the whole of a tick. A finished
// result waits in the output register while out_stall is high; the next
// item is taken meanwhile, and a later tick waits at its end until the
// register is free. Reset clears phases, voice settings, the error total
// and the output valid; the waveform table is not cleared and must be
// written before voices read it.
`default_nettype none

module wavetable_mix_error_meter
  import wtm_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 cmd,
  input  wire logic [1:0]                 channel,
  input  wire logic [WSEL_W-1:0]          waveform,
  input  wire logic [7:0]                 wave_index,
  input  wire logic signed [SAMPLE_W-1:0] wave_value,
  input  wire logic [PHASE_W-1:0]         step_rate,
  input  wire logic [GAIN_W-1:0]          volume,
  input  wire logic signed [SAMPLE_W-1:0] target_sample,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [SAMPLE_W-1:0]      mixed_sample,
  output logic [TOTAL_W-1:0]              error_total,
  output logic                            exact_so_far
);

  ctl_t                ctl;
  logic [VOICE_IW-1:0] vsel;
  logic [TABLE_AW-1:0] raddr;
  logic [TABLE_AW-1:0] waddr;
  logic [SAMPLE_W-1:0] rdata;
  logic                wave_ok;
  logic                wr_ok;
  logic [GAIN_W-1:0]   gain;

  // table writes to waveforms past the table are dropped
  assign wr_ok = {1'b0, waveform} < 9'(NUM_WAVES);
  assign waddr = TABLE_AW'({waveform, wave_index});

  wtm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .ctl       (ctl),
    .vsel      (vsel)
  );

  wtm_voices u_voices (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .vsel      (vsel),
    .channel   (channel),
    .waveform  (waveform),
    .step_rate (step_rate),
    .volume    (volume),
    .raddr     (raddr),
    .wave_ok   (wave_ok),
    .gain      (gain)
  );

  wtm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ctl.wave_wr && wr_ok),
    .waddr (waddr),
    .wdata (wave_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  wtm_arith u_arith (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .target_sample (target_sample),
    .rdata         (rdata),
    .wave_ok       (wave_ok),
    .gain          (gain),
    .mixed_sample  (mixed_sample),
    .error_total   (error_total),
    .exact_so_far  (exact_so_far)
  );

`ifndef SYNTHESIS
  // a tick keeps the input side busy after it is taken
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && cmd == CMD_TICK) |=> in_stall)
    else $error("input taken during a tick");

  // the exact flag agrees with the total it is shown with
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (exact_so_far == (error_total == '0)))
    else $error("exact flag disagrees with error total");

  // a new result appears only as the sequencer returns to idle
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result loaded while sequencer busy");
`endif

endmodule

`default_nettype wire

/* test/wavetable_mix_error_meter_tb.sv */
// self-checking testbench for the wavetable mix and error meter
`default_nettype none

module wavetable_mix_error_meter_tb;
  import wtm_pkg::*;

  localparam int CYCLE_LIMIT  = 800_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int NUM_FILLED   = 3;
  localparam int DIR_ROWS     = 20;
  localparam int RAND_SEGS    = 8;
  localparam int SEG_ITEMS    = 100;
  localparam int BURST_TICKS  = 40;
  localparam int DRAIN_CYCLES = 48;

  // one command item plus an optional typed-in result
  typedef struct packed {
    cmd_t               op;
    logic [1:0]         chan;
    logic [7:0]         wsel;
    logic [7:0]         idx;
    logic signed [15:0] wval;
    logic [15:0]        rate;
    logic [7:0]         vol;
    logic signed [15:0] target;
    logic               has_exp;
    logic signed [15:0] x_mix;
    logic [63:0]        x_total;
    logic               x_exact;
  } synth_cmd_t;

  typedef struct packed {
    logic signed [15:0] mix;
    logic [63:0]        total;
    logic               exact;
  } mix_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = CMD_START;
  logic [1:0] channel = '0;
  logic [WSEL_W-1:0] waveform = '0;
  logic [7:0] wave_index = '0;
  logic signed [SAMPLE_W-1:0] wave_value = '0;
  logic [PHASE_W-1:0] step_rate = '0;
  logic [GAIN_W-1:0] volume = '0;
  logic signed [SAMPLE_W-1:0] target_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] mixed_sample;
  logic [TOTAL_W-1:0] error_total;
  logic exact_so_far;

  // typed-in expectation travelling with the current item
  logic row_has_exp = 1'b0;
  logic signed [15:0] row_mix = '0;
  logic [63:0] row_total = '0;
  logic row_exact = 1'b0;

  int fail_count = 0;
  int cycle_count = 0;
  int tx_idle_max = 0;
  int rx_idle_max = 0;
  bit rx_hold_req = 1'b0;

  // shadow of the synthesiser state
  logic [15:0] wave_mem [TABLE_DEPTH];
  logic [15:0] phase_acc [NUM_VOICES];
  logic [15:0] step_reg [NUM_VOICES];
  logic [7:0]  vol_reg [NUM_VOICES];
  logic [7:0]  wave_sel [NUM_VOICES];
  logic [63:0] sq_err_acc;

  mix_result_t mix_expect_q [$];
  synth_cmd_t dir_rows [DIR_ROWS];

  wavetable_mix_error_meter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .channel      (channel),
    .waveform     (waveform),
    .wave_index   (wave_index),
    .wave_value   (wave_value),
    .step_rate    (step_rate),
    .volume       (volume),
    .target_sample(target_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .mixed_sample (mixed_sample),
    .error_total  (error_total),
    .exact_so_far (exact_so_far)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // waveforms that are fully written before any voice may select them
  function automatic logic [7:0] filled_wave(input int k);
    return (k == 0) ? 8'd0 : 8'(249 + 3 * k);
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 4;
      default: return 18;
    endcase
  endfunction

  // one sample tick: step every voice, scale, mix and accumulate the squared error
  task automatic predict_mix(input logic signed [15:0] tgt, output mix_result_t r);
    int acc;
    int prod;
    int diff;
    logic signed [15:0] smp;
    logic signed [15:0] mix;
    logic [63:0] mag;
    acc = 0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      phase_acc[v] = phase_acc[v] + step_reg[v];
      smp = '0;
      if (int'(wave_sel[v]) < NUM_WAVES)
        smp = wave_mem[{wave_sel[v], 8'(phase_acc[v] >> PHASE_SHIFT)}];
      prod = int'($signed({1'b0, vol_reg[v]})) * int'(smp);
      acc += prod >>> GAIN_SHIFT;
    end
    mix = acc[15:0];
    diff = int'(tgt) - int'(mix);
    mag = 64'((diff < 0) ? -diff : diff);
    sq_err_acc = sq_err_acc + mag * mag;
    r.mix = mix;
    r.total = sq_err_acc;
    r.exact = (sq_err_acc == 64'd0);
  endtask

  // shadow update on every accepted item
  always @(posedge clk) begin
    mix_result_t r;
    if (!rst && in_valid && !in_stall) begin
      case (cmd)
        CMD_START: begin
          for (int v = 0; v < NUM_VOICES; v++) phase_acc[v] = '0;
          sq_err_acc = '0;
        end
        CMD_WAVE: begin
          if (int'(waveform) < NUM_WAVES) wave_mem[{waveform, wave_index}] = wave_value;
        end
        CMD_CHAN: begin
          if (int'(channel) < NUM_VOICES) begin
            step_reg[channel] = step_rate;
            vol_reg[channel] = volume;
            wave_sel[channel] = waveform;
          end
        end
        default: begin
          predict_mix(target_sample, r);
          if (row_has_exp) begin
            r.mix = row_mix;
            r.total = row_total;
            r.exact = row_exact;
          end
          mix_expect_q.push_back(r);
        end
      endcase
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    mix_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (mix_expect_q.size() == 0) begin
        $error("result with no tick waiting: mixed_sample %0d error_total %0d",
               mixed_sample, error_total);
        fail_count++;
      end else begin
        e = mix_expect_q.pop_front();
        if (mixed_sample !== e.mix) begin
          $error("mixed_sample: expected %0d, actual %0d", e.mix, mixed_sample);
          fail_count++;
        end
        if (error_total !== e.total) begin
          $error("error_total: expected %0d, actual %0d", e.total, error_total);
          fail_count++;
        end
        if (exact_so_far !== e.exact) begin
          $error("exact_so_far: expected %0b, actual %0b", e.exact, exact_so_far);
          fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side: random stall per item, plus one long hold-off on request
  initial begin : rx_side
    int n;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        n = $urandom_range(0, rx_idle_max);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // present one item after a gap and hold it until taken; returns at a falling edge
  task automatic send_item(input synth_cmd_t it, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd           <= it.op;
    channel       <= it.chan;
    waveform      <= it.wsel;
    wave_index    <= it.idx;
    wave_value    <= it.wval;
    step_rate     <= it.rate;
    volume        <= it.vol;
    target_sample <= it.target;
    row_has_exp   <= it.has_exp;
    row_mix       <= it.x_mix;
    row_total     <= it.x_total;
    row_exact     <= it.x_exact;
    in_valid      <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin : stimulus
    synth_cmd_t it;
    int sel;

    for (int v = 0; v < NUM_VOICES; v++) begin
      phase_acc[v] = '0;
      step_reg[v]  = '0;
      vol_reg[v]   = '0;
      wave_sel[v]  = '0;
    end
    sq_err_acc = '0;

    // directed rows: reset state, error extremes, start, table and gain extremes
    dir_rows = '{
      '{CMD_TICK,  2'd0, 8'd0,   8'd0,   16'sd0,      16'h0000, 8'd0,   16'sd0,
        1'b1, 16'sd0, 64'd0, 1'b1},
      '{CMD_TICK,  2'd0, 8'd0,   8'd0,   16'sd0,      16'h0000, 8'd0,   -16'sd32768,
        1'b1, 16'sd0, 64'd1073741824, 1'b0},
      '{CMD_TICK,  2'd0, 8'd0,   8'd0,   16'sd0,      16'h0000, 8'd0,   16'sd32767,
        1'b1, 16'sd0, 64'd2147418113, 1'b0},
      '{CMD_START, 2'd0, 8'd0,   8'd0,   16'sd0,      16'h0000, 8'd0,   16'sd0,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_TICK,  2'd0, 8'd0,   8'd0,   16'sd0,      16'h0000, 8'd0,   16'sd0,
        1'b1, 16'sd0, 64'd0, 1'b1},
      '{CMD_WAVE,  2'd0, 8'd255, 8'd255, -16'sd32768, 16'h0000, 8'd0,   16'sd0,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_WAVE,  2'd0, 8'd255, 8'd1,   16'sd32767,  16'h0000, 8'd0,   16'sd0,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_WAVE,  2'd0, 8'd0,   8'd0,   -16'sd1,     16'h0000, 8'd0,   16'sd0,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_CHAN,  2'd3, 8'd255, 8'd0,   16'sd0,      16'hFFFF, 8'd255, 16'sd0,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_CHAN,  2'd2, 8'd255, 8'd0,   16'sd0,      16'h0100, 8'd255, 16'sd0,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_CHAN,  2'd0, 8'd0,   8'd0,   16'sd0,      16'h0000, 8'd1,   16'sd0,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_CHAN,  2'd1, 8'd0,   8'd0,   16'sd0,      16'h0000, 8'd0,   16'sd0,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_TICK,  2'd0, 8'd0,   8'd0,   16'sd0,      16'h0000, 8'd0,   16'sd32767,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_TICK,  2'd0, 8'd0,   8'd0,   16'sd0,      16'h0000, 8'd0,   -16'sd32768,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_START, 2'd0, 8'd0,   8'd0,   16'sd0,      16'h0000, 8'd0,   16'sd0,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_TICK,  2'd0, 8'd0,   8'd0,   16'sd0,      16'h0000, 8'd0,   16'sd0,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_WAVE,  2'd0, 8'd3,   8'd128, 16'sh1234,   16'h0000, 8'd0,   16'sd0,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_CHAN,  2'd1, 8'd252, 8'd0,   16'sd0,      16'h8080, 8'd128, 16'sd0,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_TICK,  2'd0, 8'd0,   8'd0,   16'sd0,      16'h0000, 8'd0,   -16'sd1,
        1'b0, 16'sd0, 64'd0, 1'b0},
      '{CMD_TICK,  2'd0, 8'd0,   8'd0,   16'sd0,      16'h0000, 8'd0,   16'sd1,
        1'b0, 16'sd0, 64'd0, 1'b0}
    };

    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // fill every waveform a voice may select, back to back
    for (int k = 0; k < NUM_FILLED; k++) begin
      for (int i = 0; i < WAVE_LEN; i++) begin
        it = '0;
        it.op     = CMD_WAVE;
        it.chan   = 2'($urandom);
        it.wsel   = filled_wave(k);
        it.idx    = 8'(i);
        it.wval   = 16'($urandom);
        it.rate   = 16'($urandom);
        it.vol    = 8'($urandom);
        it.target = 16'($urandom);
        send_item(it, 0);
      end
    end

    // directed table
    tx_idle_max = 18;
    rx_idle_max = 18;
    for (int r = 0; r < DIR_ROWS; r++)
      send_item(dir_rows[r], $urandom_range(0, tx_idle_max));

    // long receiver hold-off while ticks keep coming
    tx_idle_max = 0;
    rx_hold_req = 1'b1;
    for (int b = 0; b < BURST_TICKS; b++) begin
      it = '0;
      it.op     = CMD_TICK;
      it.target = 16'($urandom);
      send_item(it, 0);
    end

    // random commands in segments of differing idle pressure
    for (int s = 0; s < RAND_SEGS; s++) begin
      tx_idle_max = pick_idle();
      rx_idle_max = pick_idle();
      for (int k = 0; k < SEG_ITEMS; k++) begin
        it = '0;
        it.chan   = 2'($urandom);
        it.wsel   = 8'($urandom);
        it.idx    = 8'($urandom);
        it.wval   = 16'($urandom);
        it.rate   = 16'($urandom);
        it.vol    = 8'($urandom);
        it.target = 16'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
          it.op = CMD_START;
        end else if (sel < 25) begin
          it.op = CMD_WAVE;
          if ($urandom_range(0, 9) < 7) it.wsel = filled_wave($urandom_range(0, NUM_FILLED - 1));
          if ($urandom_range(0, 9) == 0) it.wval = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end else if (sel < 45) begin
          it.op = CMD_CHAN;
          it.wsel = filled_wave($urandom_range(0, NUM_FILLED - 1));
          if ($urandom_range(0, 9) == 0) it.vol = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          if ($urandom_range(0, 9) == 0) it.rate = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else begin
          it.op = CMD_TICK;
          if ($urandom_range(0, 9) == 0) it.target = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        send_item(it, $urandom_range(0, tx_idle_max));
      end
    end
    in_valid <= 1'b0;

    // drain and settle
    while (mix_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
design/wtm_pkg.sv
design/wtm_ram.sv
design/wtm_voices.sv
design/wtm_arith.sv
design/wtm_ctrl.sv
design/wavetable_mix_error_meter.sv
test/wavetable_mix_error_meter_tb.sv
